[rtl/b64c_pkg.sv]
// Shared types, constants and alphabet functions for the Base64 stream codec.
package b64c_pkg;

   localparam int unsigned QUEUE_DEPTH_DEF = 2;
   localparam int unsigned MAX_ITEMS = 4;

   localparam logic [7:0] PAD_CHAR = 8'h3D;

   typedef enum logic [1:0] {
      STATUS_DATA = 2'd0,
      STATUS_END  = 2'd1,
      STATUS_ERR  = 2'd2
   } status_type;

   // Results caused by one input transfer, slot 0 first.
   typedef struct packed {
      logic [2:0]                  count;
      logic [MAX_ITEMS-1:0][7:0]   data;
      logic [MAX_ITEMS-1:0][1:0]   status;
      logic [MAX_ITEMS-1:0]        last;
   } bundle_type;

   function automatic logic [7:0] enc_char(input logic [5:0] v);
      logic [7:0] w;
      w = {2'b00, v};
      if (v < 6'd26) begin
         return w + 8'h41;
      end else if (v < 6'd52) begin
         return w + 8'h47;
      end else if (v < 6'd62) begin
         return w - 8'h04;
      end else if (v == 6'd62) begin
         return 8'h2B;
      end
      return 8'h2F;
   endfunction

   // {valid, six-bit value}
   function automatic logic [6:0] dec_char(input logic [7:0] c);
      logic [7:0] t;
      t = 8'h00;
      if (c >= 8'h41 && c <= 8'h5A) begin
         t = c - 8'h41;
         return {1'b1, t[5:0]};
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         t = c - 8'h47;
         return {1'b1, t[5:0]};
      end else if (c >= 8'h30 && c <= 8'h39) begin
         t = c + 8'h04;
         return {1'b1, t[5:0]};
      end else if (c == 8'h2B) begin
         return {1'b1, 6'd62};
      end else if (c == 8'h2F) begin
         return {1'b1, 6'd63};
      end
      return 7'd0;
   endfunction

endpackage

[rtl/b64c_front.sv]
// Front end: accepts transfers, tracks group state and builds result bundles.
module b64c_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic                csr_wr_data,
   input  logic                accept,
   input  logic [7:0]          in_byte,
   input  logic                in_last,
   output logic                push,
   output b64c_pkg::bundle_type push_data
);
   import b64c_pkg::*;

   logic       dir_ff;
   logic [1:0] phase_ff, phase_in;
   logic [7:0] carry_ff, carry_in;
   logic       stopped_ff, stopped_in;
   logic       errored_ff, errored_in;
   bundle_type bnd;
   logic [6:0] dec;

   always_comb begin
      bnd        = '0;
      phase_in   = phase_ff;
      carry_in   = carry_ff;
      stopped_in = stopped_ff;
      errored_in = errored_ff;
      dec        = dec_char(in_byte);
      if (!dir_ff) begin
         case (phase_ff)
            2'd1: begin
               bnd.data[0] = enc_char({carry_ff[1:0], in_byte[7:4]});
               carry_in    = {4'b0, in_byte[3:0]};
               phase_in    = 2'd2;
               bnd.count   = 3'd1;
               if (in_last) begin
                  bnd.data[1] = enc_char({in_byte[3:0], 2'b00});
                  bnd.data[2] = PAD_CHAR;
                  bnd.last[2] = 1'b1;
                  bnd.count   = 3'd3;
               end
            end
            2'd2: begin
               bnd.data[0] = enc_char({carry_ff[3:0], in_byte[7:6]});
               bnd.data[1] = enc_char(in_byte[5:0]);
               bnd.last[1] = in_last;
               bnd.count   = 3'd2;
               carry_in    = 8'd0;
               phase_in    = 2'd0;
            end
            default: begin
               bnd.data[0] = enc_char(in_byte[7:2]);
               carry_in    = {6'b0, in_byte[1:0]};
               phase_in    = 2'd1;
               bnd.count   = 3'd1;
               if (in_last) begin
                  bnd.data[1] = enc_char({in_byte[1:0], 4'b0000});
                  bnd.data[2] = PAD_CHAR;
                  bnd.data[3] = PAD_CHAR;
                  bnd.last[3] = 1'b1;
                  bnd.count   = 3'd4;
               end
            end
         endcase
         if (in_last) begin
            phase_in = 2'd0;
            carry_in = 8'd0;
         end
      end else if (!errored_ff) begin
         if (!stopped_ff) begin
            if (in_byte == PAD_CHAR || in_byte == 8'd0 || in_byte[7]) begin
               stopped_in = 1'b1;
            end else if (!dec[6]) begin
               bnd.status[0] = STATUS_ERR;
               bnd.last[0]   = 1'b1;
               bnd.count     = 3'd1;
               errored_in    = 1'b1;
            end else begin
               case (phase_ff)
                  2'd0: begin
                     carry_in = {dec[5:0], 2'b00};
                     phase_in = 2'd1;
                  end
                  2'd1: begin
                     bnd.data[0] = carry_ff | {6'b0, dec[5:4]};
                     bnd.count   = 3'd1;
                     carry_in    = {dec[3:0], 4'b0000};
                     phase_in    = 2'd2;
                  end
                  2'd2: begin
                     bnd.data[0] = carry_ff | {4'b0, dec[5:2]};
                     bnd.count   = 3'd1;
                     carry_in    = {dec[1:0], 6'b000000};
                     phase_in    = 2'd3;
                  end
                  default: begin
                     bnd.data[0] = carry_ff | {2'b0, dec[5:0]};
                     bnd.count   = 3'd1;
                     carry_in    = 8'd0;
                     phase_in    = 2'd0;
                  end
               endcase
            end
         end
         if (in_last && !errored_in) begin
            bnd.data[bnd.count[1:0]]   = 8'd0;
            bnd.status[bnd.count[1:0]] = STATUS_END;
            bnd.last[bnd.count[1:0]]   = 1'b1;
            bnd.count                  = bnd.count + 3'd1;
         end
      end
      if (dir_ff && in_last) begin
         phase_in   = 2'd0;
         carry_in   = 8'd0;
         stopped_in = 1'b0;
         errored_in = 1'b0;
      end
   end

   assign push      = accept && (bnd.count != 3'd0);
   assign push_data = bnd;

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff     <= 1'b0;
         phase_ff   <= 2'd0;
         carry_ff   <= 8'd0;
         stopped_ff <= 1'b0;
         errored_ff <= 1'b0;
      end else if (csr_wr_en) begin
         dir_ff     <= csr_wr_data;
         phase_ff   <= 2'd0;
         carry_ff   <= 8'd0;
         stopped_ff <= 1'b0;
         errored_ff <= 1'b0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         carry_ff   <= carry_in;
         stopped_ff <= stopped_in;
         errored_ff <= errored_in;
      end
   end

endmodule

[rtl/b64c_queue.sv]
// Small bundle queue between the front end and the output sequencer.
module b64c_queue #(
   parameter int unsigned DEPTH = b64c_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  b64c_pkg::bundle_type push_data,
   input  logic                 pop,
   output b64c_pkg::bundle_type head,
   output logic                 full,
   output logic                 empty
);
   import b64c_pkg::*;

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   bundle_type           mem [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]     count_ff;

   assign full  = (count_ff == FULL_CNT);
   assign empty = (count_ff == '0);
   assign head  = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

[rtl/b64c_back.sv]
// Output sequencer: walks each bundle and drives the registered result channel.
module b64c_back (
   input  logic                 clock,
   input  logic                 reset,
   input  b64c_pkg::bundle_type head,
   input  logic                 empty,
   output logic                 pop,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,
   output logic [1:0]           rsp_tuser,
   output logic                 rsp_tlast
);
   import b64c_pkg::*;

   logic [1:0] idx_ff;
   logic       valid_ff;
   logic [7:0] data_ff;
   logic [1:0] user_ff;
   logic       last_ff;
   logic       load;
   logic       at_end;

   assign load   = !empty && (!valid_ff || rsp_tready);
   assign at_end = ({1'b0, idx_ff} == head.count - 3'd1);
   assign pop    = load && at_end;

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= head.data[idx_ff];
         user_ff <= head.status[idx_ff];
         last_ff <= head.last[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            idx_ff   <= at_end ? 2'd0 : idx_ff + 2'd1;
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = last_ff;

endmodule

[rtl/base64_stream_codec.sv]
// Base64 stream codec top level: front end, bundle queue and output sequencer.
// Encode (csr direction 0) turns bytes into characters of the standard alphabet,
// with '=' padding where the byte marked tlast leaves a group incomplete;
// decode (direction 1) turns characters into bytes and closes each message
// with an end marker (tuser 1), or reports a bad character (tuser 2) and
// drops the rest of that message. A transfer is taken every cycle while the
// queue has room; the result channel sends one item per cycle while
// rsp_tready is high, so throughput is set by it: an encoded byte yields
// 1 to 4 results (4 per 3 bytes in steady state), a decoded character at most 2.
// The first result of a transfer passes the bundle queue and output register
// before it is valid. Write the direction only while no message is in flight.
module base64_stream_codec #(
   parameter int unsigned QUEUE_DEPTH = b64c_pkg::QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [1:0] rsp_tuser,   // [1:0] status
   output logic       rsp_tlast
);
   import b64c_pkg::*;

   logic       accept;
   logic       push;
   logic       pop;
   logic       full;
   logic       empty;
   bundle_type push_data;
   bundle_type head;

   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   b64c_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .accept      (accept),
      .in_byte     (req_tdata),
      .in_last     (req_tlast),
      .push        (push),
      .push_data   (push_data)
   );

   b64c_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .full      (full),
      .empty     (empty)
   );

   b64c_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .empty      (empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[rtl/b64c_checker.sv]
// Port-level checks for the Base64 stream codec, bound to the top level.
module b64c_checker (
   input logic       clock,
   input logic       reset,
   input logic       csr_wr_en,
   input logic       csr_wr_data,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [1:0] rsp_tuser,
   input logic       rsp_tlast
);
   import b64c_pkg::*;

   logic dir_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff <= 1'b0;
      end else if (csr_wr_en) begin
         dir_ff <= csr_wr_data;
      end
   end

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == STATUS_DATA || rsp_tuser == STATUS_END ||
                      rsp_tuser == STATUS_ERR))
      else $error("bad status code on result");

   a_marker_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STATUS_DATA |-> rsp_tlast && rsp_tdata == 8'd0)
      else $error("marker without tlast or with nonzero data");

   a_encode_data_only: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !dir_ff |-> rsp_tuser == STATUS_DATA)
      else $error("marker produced while encoding");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

endmodule

bind base64_stream_codec b64c_checker u_b64c_checker (
   .clock       (clock),
   .reset       (reset),
   .csr_wr_en   (csr_wr_en),
   .csr_wr_data (csr_wr_data),
   .rsp_tvalid  (rsp_tvalid),
   .rsp_tready  (rsp_tready),
   .rsp_tdata   (rsp_tdata),
   .rsp_tuser   (rsp_tuser),
   .rsp_tlast   (rsp_tlast)
);

[sim/base64_result_checker.sv]
// Checker for the Base64 stream codec: predicts results from accepted transfers and compares.
`timescale 1ns / 100ps

module base64_result_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       req_tlast,
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,
   input  logic [1:0] rsp_tuser,
   input  logic       rsp_tlast,
   output int         outstanding,
   output int         failures
);
   import b64c_pkg::*;

   localparam logic [0:63][7:0] SYMBOLS =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [7:0] value;
      status_type status;
      logic       last;
   } codec_result_type;

   codec_result_type pending_results[$];
   logic             decoding;
   logic [1:0]       phase;
   logic [7:0]       carry;
   logic             stopped;
   logic             errored;
   int               mismatch_count;

   function automatic logic [6:0] symbol_value(input logic [7:0] c);
      for (int i = 0; i < 64; i++) begin
         if (SYMBOLS[i] == c) begin
            return {1'b1, 6'(i)};
         end
      end
      return 7'd0;
   endfunction

   task automatic clear_stream();
      phase = 2'd0;
      carry = 8'd0;
      stopped = 1'b0;
      errored = 1'b0;
   endtask

   task automatic expect_result(input logic [7:0] value, input status_type status,
                                input logic last);
      codec_result_type r;
      r.value = value;
      r.status = status;
      r.last = last;
      pending_results.push_back(r);
   endtask

   task automatic encode_byte(input logic [7:0] b, input logic last);
      case ((phase == 2'd3) ? 2'd0 : phase)
         2'd0: begin
            expect_result(SYMBOLS[b[7:2]], STATUS_DATA, 1'b0);
            carry = {6'd0, b[1:0]};
            phase = 2'd1;
            if (last) begin
               expect_result(SYMBOLS[{b[1:0], 4'd0}], STATUS_DATA, 1'b0);
               expect_result(PAD_CHAR, STATUS_DATA, 1'b0);
               expect_result(PAD_CHAR, STATUS_DATA, 1'b1);
            end
         end
         2'd1: begin
            expect_result(SYMBOLS[{carry[1:0], b[7:4]}], STATUS_DATA, 1'b0);
            carry = {4'd0, b[3:0]};
            phase = 2'd2;
            if (last) begin
               expect_result(SYMBOLS[{b[3:0], 2'd0}], STATUS_DATA, 1'b0);
               expect_result(PAD_CHAR, STATUS_DATA, 1'b1);
            end
         end
         default: begin
            expect_result(SYMBOLS[{carry[3:0], b[7:6]}], STATUS_DATA, 1'b0);
            expect_result(SYMBOLS[b[5:0]], STATUS_DATA, last);
            carry = 8'd0;
            phase = 2'd0;
         end
      endcase
      if (last) begin
         clear_stream();
      end
   endtask

   task automatic decode_char(input logic [7:0] c, input logic last);
      logic [6:0] sym;
      logic [5:0] v;
      sym = symbol_value(c);
      v = sym[5:0];
      if (errored) begin
         if (last) begin
            clear_stream();
         end
         return;
      end
      if (!stopped) begin
         if (c == PAD_CHAR || c == 8'h00 || c[7]) begin
            stopped = 1'b1;
         end else if (!sym[6]) begin
            expect_result(8'h00, STATUS_ERR, 1'b1);
            errored = 1'b1;
            if (last) begin
               clear_stream();
            end
            return;
         end else begin
            case (phase)
               2'd0: begin
                  carry = {v, 2'd0};
                  phase = 2'd1;
               end
               2'd1: begin
                  expect_result(carry | {6'd0, v[5:4]}, STATUS_DATA, 1'b0);
                  carry = {v[3:0], 4'd0};
                  phase = 2'd2;
               end
               2'd2: begin
                  expect_result(carry | {4'd0, v[5:2]}, STATUS_DATA, 1'b0);
                  carry = {v[1:0], 6'd0};
                  phase = 2'd3;
               end
               default: begin
                  expect_result(carry | {2'd0, v}, STATUS_DATA, 1'b0);
                  carry = 8'd0;
                  phase = 2'd0;
               end
            endcase
         end
      end
      if (last) begin
         expect_result(8'h00, STATUS_END, 1'b1);
         clear_stream();
      end
   endtask

   task automatic check_result();
      codec_result_type want;
      if (pending_results.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t: unexpected result %h/%0d/%b", $time, rsp_tdata, rsp_tuser,
                     rsp_tlast);
         end
         return;
      end
      want = pending_results.pop_front();
      if (rsp_tdata !== want.value || rsp_tuser !== want.status || rsp_tlast !== want.last)
      begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t: result mismatch, expected %h/%0d/%b, got %h/%0d/%b", $time,
                     want.value, want.status, want.last, rsp_tdata, rsp_tuser, rsp_tlast);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         decoding = 1'b0;
         clear_stream();
         pending_results.delete();
      end else begin
         if (csr_wr_en) begin
            decoding = csr_wr_data;
            clear_stream();
         end
         if (req_tvalid && req_tready) begin
            if (decoding) begin
               decode_char(req_tdata, req_tlast);
            end else begin
               encode_byte(req_tdata, req_tlast);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            check_result();
         end
      end
      outstanding <= pending_results.size();
      failures <= mismatch_count;
   end

endmodule

[sim/tb_base64_stream_codec.sv]
// Testbench top for the Base64 stream codec: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_base64_stream_codec;
   import b64c_pkg::*;

   localparam logic [0:63][7:0] SYMBOLS =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
   localparam int SETTLE_CYCLES = 10;
   localparam int QUIET_LIMIT = 2000;

   logic       clock;
   logic       reset;
   logic       csr_wr_en;
   logic       csr_wr_data;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;
   logic       req_tlast;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic       rsp_tlast;
   int         outstanding;
   int         failures;
   int         send_idle_pct = 0;
   int         recv_idle_pct = 0;
   int         quiet_cycles = 0;
   int         items_sent = 0;

   base64_stream_codec u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   base64_result_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .outstanding(outstanding),
      .failures   (failures)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   always @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         items_sent <= items_sent + 1;
      end
   end

   task automatic send_item(input logic [7:0] value, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= value;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
   endtask

   task automatic send_string(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_item(s[i], i == s.len() - 1);
      end
   endtask

   // all results in, then room for transfers that produce nothing
   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_direction(input logic decode);
      wait_quiet();
      csr_wr_en <= 1'b1;
      csr_wr_data <= decode;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_bytes();
      int len;
      len = ($urandom_range(9) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 7);
      for (int i = 0; i < len; i++) begin
         send_item(8'($urandom_range(255)), i == len - 1);
      end
   endtask

   // mostly well-formed text; some with noise, truncation or data after padding
   task automatic send_text();
      logic [7:0] text[$];
      int groups;
      int tail;
      int kind;
      int keep;
      groups = $urandom_range(0, 2);
      tail = $urandom_range(0, 2);
      if (groups == 0 && tail == 0) begin
         groups = 1;
      end
      repeat (4 * groups) text.push_back(SYMBOLS[$urandom_range(63)]);
      if (tail != 0) begin
         repeat (tail + 1) text.push_back(SYMBOLS[$urandom_range(63)]);
         repeat (3 - tail) text.push_back(PAD_CHAR);
      end
      kind = $urandom_range(99);
      if (kind < 12) begin
         text[$urandom_range(text.size() - 1)] = 8'($urandom_range(255));
      end else if (kind < 20) begin
         keep = $urandom_range(1, text.size());
         while (text.size() > keep) begin
            void'(text.pop_back());
         end
      end else if (kind < 27) begin
         text.push_back(PAD_CHAR);
         repeat ($urandom_range(1, 3)) text.push_back(8'($urandom_range(255)));
      end
      for (int i = 0; i < text.size(); i++) begin
         send_item(text[i], i == text.size() - 1);
      end
   endtask

   task automatic run_block(input logic decode, input int count);
      int goal;
      goal = items_sent + count;
      write_direction(decode);
      while (items_sent < goal) begin
         if (decode) begin
            send_text();
         end else begin
            send_bytes();
         end
      end
   endtask

   initial begin
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_wr_data <= 1'b0;
      req_tvalid <= 1'b0;
      req_tdata <= 8'h00;
      req_tlast <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed encode, direction at reset value
      send_item(8'h00, 1'b1);
      send_item(8'hFF, 1'b1);
      send_item(8'hFC, 1'b0);
      send_item(8'h03, 1'b1);
      send_item(8'hF0, 1'b0);
      send_item(8'h0F, 1'b0);
      send_item(8'hC0, 1'b1);
      send_item(8'h3F, 1'b0);
      send_item(8'h01, 1'b0);
      send_item(8'h80, 1'b0);
      send_item(8'h7E, 1'b1);

      // directed decode: partial byte, stop on last, bad char, NUL, high byte
      write_direction(1'b1);
      send_string("TWFuQ");
      send_string("+/9=");
      send_string("Zz?x");
      send_string("*");
      send_item(8'h00, 1'b0);
      send_item(8'h41, 1'b1);
      send_item(8'h80, 1'b1);

      send_idle_pct = 8;
      recv_idle_pct = 59;
      run_block(1'b0, 60);
      run_block(1'b1, 80);
      send_idle_pct = 59;
      recv_idle_pct = 8;
      run_block(1'b1, 80);
      run_block(1'b0, 60);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_block(1'b0, 60);
      run_block(1'b1, 80);

      wait_quiet();
      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
